// ===== rtl/lmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver package
// Shared command, result and code definitions for the row scan driver.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_REFRESH = 2'd1;
    localparam logic [1:0] FUNC_CAL     = 2'd2;

    localparam logic [1:0] REG_CAL_RED   = 2'd0;
    localparam logic [1:0] REG_CAL_GREEN = 2'd1;
    localparam logic [1:0] REG_CAL_BLUE  = 2'd2;

    localparam logic [5:0] CAL_RESET = 6'd63;

    localparam logic [3:0] BITS_IMAGE = 4'd8;
    localparam logic [3:0] BITS_CAL   = 4'd6;

    localparam logic [1:0] SUB_BLUE  = 2'd0;
    localparam logic [1:0] SUB_GREEN = 2'd1;
    localparam logic [1:0] SUB_RED   = 2'd2;

    typedef enum logic [1:0] {
        K_WRITE   = 2'd0,
        K_REFRESH = 2'd1,
        K_CAL     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  col;
        logic [2:0]  row;
        logic [23:0] pixel;
    } t_cmd;

    typedef struct packed {
        logic [7:0] shift_value;
        logic [3:0] shift_bits;
        logic       bank_eight_bit;
        logic       latch;
        logic [7:0] row_drive;
        logic       last;
    } t_beat;

    function automatic logic [7:0] row_hot(input logic [3:0] row);
        logic [7:0] v;
        v = '0;
        if (row < 4'd8) begin
            v[row[2:0]] = 1'b1;
        end
        return v;
    endfunction

endpackage

// ===== rtl/lmrs_if.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver channels
// Valid/ready channels for input items, result beats and register writes.
// ----------------------------------------------------------------------------
interface lmrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] pixel_col;
    logic [2:0] pixel_row;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;

    modport source (
        output valid, func, pixel_col, pixel_row, red_value, green_value, blue_value,
        input  ready
    );
    modport sink (
        input  valid, func, pixel_col, pixel_row, red_value, green_value, blue_value,
        output ready
    );
endinterface

interface lmrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] shift_value;
    logic [3:0] shift_bits;
    logic       bank_eight_bit;
    logic       latch;
    logic [7:0] row_drive;
    logic       last;

    modport source (
        output valid, shift_value, shift_bits, bank_eight_bit, latch, row_drive, last,
        input  ready
    );
    modport sink (
        input  valid, shift_value, shift_bits, bank_eight_bit, latch, row_drive, last,
        output ready
    );
endinterface

interface lmrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [5:0] data;

    modport source (
        output valid, reg_index, data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, data,
        output ready
    );
endinterface

// ===== rtl/led_matrix_row_scan_driver_core.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver core
// Frame store and row scan sequencer for an RGB LED matrix behind a serial
// constant-current driver and a one-hot row select.
//
//   Port    Direction  Beat
//   i_in    sink       pixel write, refresh tick or calibration request
//   o_out   source     one shifted value with bank, latch and row enable
//   i_cfg   sink       calibration level register write
//
// A pixel write is a single frame store write in the scan engine. A refresh
// runs one frame store read per column followed by three output beats. A
// calibration run emits three output beats per column. Reset clears the
// frame store through per-entry valid bits, so no clearing pass is needed. A
// two-entry command queue keeps input beats flowing while the output stage
// stalls, until the queue fills.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver_core #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmrs_in_if.sink     i_in,
    lmrs_out_if.source  o_out,
    lmrs_cfg_if.sink    i_cfg
);
    import lmrs_pkg::*;

    logic [5:0] r_cal_red;
    logic [5:0] r_cal_green;
    logic [5:0] r_cal_blue;

    logic w_push;
    logic w_full;
    logic w_empty;
    logic w_pop;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_red   <= CAL_RESET;
            r_cal_green <= CAL_RESET;
            r_cal_blue  <= CAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_CAL_RED:   r_cal_red   <= i_cfg.data;
                REG_CAL_GREEN: r_cal_green <= i_cfg.data;
                REG_CAL_BLUE:  r_cal_blue  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    lmrs_front #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_front_cmd)
    );

    lmrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd)
    );

    lmrs_back #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .i_cal_red   (r_cal_red),
        .i_cal_green (r_cal_green),
        .i_cal_blue  (r_cal_blue),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/lmrs_front.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver front end
// Accepts input beats, decodes the function code and drops unused codes and
// out-of-range pixel writes before they reach the command queue.
// ----------------------------------------------------------------------------
module lmrs_front #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 8
) (
    lmrs_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output lmrs_pkg::t_cmd  o_cmd
);
    import lmrs_pkg::*;

    logic w_keep;

    always_comb begin
        w_keep     = 1'b0;
        o_cmd.kind = K_WRITE;
        unique case (i_in.func)
            FUNC_WRITE: begin
                o_cmd.kind = K_WRITE;
                w_keep = (5'(i_in.pixel_col) < 5'(COLUMN_COUNT)) &&
                         (5'(i_in.pixel_row) < 5'(ROW_COUNT));
            end
            FUNC_REFRESH: begin
                o_cmd.kind = K_REFRESH;
                w_keep = 1'b1;
            end
            FUNC_CAL: begin
                o_cmd.kind = K_CAL;
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
        o_cmd.col   = i_in.pixel_col;
        o_cmd.row   = i_in.pixel_row;
        o_cmd.pixel = {i_in.red_value, i_in.green_value, i_in.blue_value};
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && w_keep;

endmodule

// ===== rtl/lmrs_queue.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver command queue
// Two-entry queue that decouples the front end from the scan engine.
// ----------------------------------------------------------------------------
module lmrs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmrs_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output lmrs_pkg::t_cmd  o_cmd
);
    import lmrs_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_entry[r_rptr];

endmodule

// ===== rtl/lmrs_back.sv =====
// ----------------------------------------------------------------------------
// LED matrix row scan driver scan engine
// Holds the frame store and the row state, executes pixel writes and
// sequences refresh and calibration runs into the registered result stage.
// ----------------------------------------------------------------------------
module lmrs_back #(
    parameter int ROW_COUNT    = 8,
    parameter int COLUMN_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lmrs_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    input  logic [5:0]      i_cal_red,
    input  logic [5:0]      i_cal_green,
    input  logic [5:0]      i_cal_blue,
    lmrs_out_if.source      o_out
);
    import lmrs_pkg::*;

    localparam int DEPTH  = ROW_COUNT * COLUMN_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(ROW_COUNT);
    localparam int COL_W  = $clog2(COLUMN_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EMIT = 4'b0100,
        S_CAL  = 4'b1000
    } t_state;

    logic [23:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [23:0]      r_rd_data;
    logic             r_rd_valid;

    t_state           r_state;
    logic [ROW_W-1:0] r_scan_row;
    logic [7:0]       r_row_enable;
    logic [COL_W-1:0] r_col;
    logic [1:0]       r_sub;
    logic             r_out_valid;
    t_beat            r_out;

    t_state           n_state;
    logic [ROW_W-1:0] n_scan_row;
    logic [7:0]       n_row_enable;
    logic [COL_W-1:0] n_col;
    logic [1:0]       n_sub;
    t_beat            n_beat;

    logic              w_slot;
    logic              w_load;
    logic              w_we;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_addr;
    logic [8:0]        w_cmd_lin;
    logic [8:0]        w_scan_lin;
    logic              w_fin;
    logic [7:0]        w_hot;
    logic [7:0]        w_byte;
    logic [ROW_W-1:0]  w_next_row;

    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_cmd_lin  = 9'(i_cmd.row) * 9'(COLUMN_COUNT) + 9'(i_cmd.col);
    assign w_scan_lin = 9'(r_scan_row) * 9'(COLUMN_COUNT) + 9'(r_col);
    assign w_fin      = (r_sub == SUB_RED) && (r_col == COL_W'(COLUMN_COUNT - 1));
    assign w_hot      = row_hot(4'(r_scan_row));
    assign w_next_row = (r_scan_row == ROW_W'(ROW_COUNT - 1)) ? '0 : r_scan_row + 1'b1;

    always_comb begin
        unique case (r_sub)
            SUB_BLUE:  w_byte = r_rd_data[7:0];
            SUB_GREEN: w_byte = r_rd_data[15:8];
            SUB_RED:   w_byte = r_rd_data[23:16];
            default:   w_byte = 8'd0;
        endcase
        if (!r_rd_valid) begin
            w_byte = 8'd0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_scan_row   = r_scan_row;
        n_row_enable = r_row_enable;
        n_col        = r_col;
        n_sub        = r_sub;
        n_beat       = r_out;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_rd_en      = 1'b0;
        w_load       = 1'b0;
        w_addr       = ADDR_W'(w_cmd_lin);
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_WRITE: begin
                            w_we = 1'b1;
                        end
                        K_REFRESH: begin
                            n_row_enable = 8'd0;
                            n_col        = '0;
                            n_sub        = SUB_BLUE;
                            n_state      = S_READ;
                        end
                        K_CAL: begin
                            n_col   = '0;
                            n_sub   = SUB_BLUE;
                            n_state = S_CAL;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                w_addr  = ADDR_W'(w_scan_lin);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_load                = 1'b1;
                    n_beat.shift_value    = w_byte;
                    n_beat.shift_bits     = BITS_IMAGE;
                    n_beat.bank_eight_bit = 1'b1;
                    n_beat.latch          = w_fin;
                    n_beat.row_drive      = w_fin ? w_hot : 8'd0;
                    n_beat.last           = w_fin;
                    if (r_sub == SUB_RED) begin
                        n_sub = SUB_BLUE;
                        if (w_fin) begin
                            n_row_enable = w_hot;
                            n_scan_row   = w_next_row;
                            n_state      = S_IDLE;
                        end else begin
                            n_col   = r_col + 1'b1;
                            n_state = S_READ;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            S_CAL: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    unique case (r_sub)
                        SUB_BLUE:  n_beat.shift_value = {2'b00, i_cal_blue};
                        SUB_GREEN: n_beat.shift_value = {2'b00, i_cal_green};
                        default:   n_beat.shift_value = {2'b00, i_cal_red};
                    endcase
                    n_beat.shift_bits     = BITS_CAL;
                    n_beat.bank_eight_bit = 1'b0;
                    n_beat.latch          = w_fin;
                    n_beat.row_drive      = r_row_enable;
                    n_beat.last           = w_fin;
                    if (r_sub == SUB_RED) begin
                        n_sub = SUB_BLUE;
                        if (w_fin) begin
                            n_state = S_IDLE;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scan_row   <= '0;
            r_row_enable <= 8'd0;
            r_col        <= '0;
            r_sub        <= SUB_BLUE;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_scan_row   <= n_scan_row;
            r_row_enable <= n_row_enable;
            r_col        <= n_col;
            r_sub        <= n_sub;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= i_cmd.pixel;
        end
        if (w_rd_en) begin
            r_rd_data  <= r_mem[w_addr];
            r_rd_valid <= r_valid[w_addr];
        end
        if (w_load) begin
            r_out <= n_beat;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.shift_value    = r_out.shift_value;
    assign o_out.shift_bits     = r_out.shift_bits;
    assign o_out.bank_eight_bit = r_out.bank_eight_bit;
    assign o_out.latch          = r_out.latch;
    assign o_out.row_drive      = r_out.row_drive;
    assign o_out.last           = r_out.last;

endmodule

// ===== sim/led_matrix_row_scan_driver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scan driver core testbench
// Feeds pixel writes, refresh ticks and calibration runs into the core and
// predicts every shifted beat from its own copy of the frame store, scan row,
// row enable and calibration levels. Each output beat is checked field by
// field against the oldest prediction, under random idling on both channels
// and one long output stall.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver_core_tb;
    import lmrs_pkg::*;

    localparam int ROWS         = 8;
    localparam int COLS         = 8;
    localparam int SETTLE       = 2 * (4 * COLS + 1) + 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] col;
        logic [2:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_scan_cmd;

    logic clk;
    logic rst_n;

    lmrs_in_if  in_if();
    lmrs_out_if out_if();
    lmrs_cfg_if cfg_if();

    led_matrix_row_scan_driver_core #(
        .ROW_COUNT    (ROWS),
        .COLUMN_COUNT (COLS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_scan_cmd  pending_cmds[$];
    t_beat      expected_beats[$];
    t_scan_cmd  cur_cmd;
    int         cmds_queued;
    int         cmds_accepted;
    int         fail_cnt;
    int         snd_idle;
    int         rcv_idle;
    int         cycle_cnt;
    logic       hold_req;
    logic       hold_used;
    int         hold_left;

    logic [23:0] frame_px [ROWS * COLS];
    logic [2:0]  scan_row;
    logic [7:0]  row_en;
    logic [5:0]  cal_lvl [3];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_scan_beats(t_scan_cmd cmd);
        t_beat       b;
        logic [23:0] px;
        int          n;
        int          c;
        int          s;
        n = 0;
        case (cmd.func)
            FUNC_WRITE: begin
                if (cmd.col < COLS && cmd.row < ROWS) begin
                    frame_px[cmd.row * COLS + cmd.col] = {cmd.red, cmd.green, cmd.blue};
                end
            end
            FUNC_REFRESH: begin
                if (scan_row >= ROWS) begin
                    scan_row = '0;
                end
                row_en = '0;
                for (c = 0; c < COLS; c++) begin
                    px = frame_px[scan_row * COLS + c];
                    for (s = 0; s < 3; s++) begin
                        b.shift_value    = px[8 * s +: 8];
                        b.shift_bits     = BITS_IMAGE;
                        b.bank_eight_bit = 1'b1;
                        b.latch          = (n == 3 * COLS - 1);
                        b.last           = b.latch;
                        if (b.latch) begin
                            row_en = (scan_row < 8) ? (8'd1 << scan_row) : 8'd0;
                        end
                        b.row_drive = row_en;
                        expected_beats.push_back(b);
                        n++;
                    end
                end
                scan_row = (scan_row >= ROWS - 1) ? 3'd0 : scan_row + 3'd1;
            end
            FUNC_CAL: begin
                for (c = 0; c < COLS; c++) begin
                    for (s = 0; s < 3; s++) begin
                        case (s)
                            SUB_BLUE:  b.shift_value = {2'b00, cal_lvl[REG_CAL_BLUE]};
                            SUB_GREEN: b.shift_value = {2'b00, cal_lvl[REG_CAL_GREEN]};
                            default:   b.shift_value = {2'b00, cal_lvl[REG_CAL_RED]};
                        endcase
                        b.shift_bits     = BITS_CAL;
                        b.bank_eight_bit = 1'b0;
                        b.latch          = (n == 3 * COLS - 1);
                        b.last           = b.latch;
                        b.row_drive      = row_en;
                        expected_beats.push_back(b);
                        n++;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_scan_beats(cur_cmd);
                cmds_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    cur_cmd = pending_cmds.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.func        <= cur_cmd.func;
                    in_if.pixel_col   <= cur_cmd.col;
                    in_if.pixel_row   <= cur_cmd.row;
                    in_if.red_value   <= cur_cmd.red;
                    in_if.green_value <= cur_cmd.green;
                    in_if.blue_value  <= cur_cmd.blue;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : beat_monitor
        t_beat want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("output beat with no expectation: shift_value %0h last %0b",
                           out_if.shift_value, out_if.last);
                    fail_cnt++;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_if.shift_value !== want.shift_value) begin
                        $error("shift_value expected %0h actual %0h",
                               want.shift_value, out_if.shift_value);
                        fail_cnt++;
                    end
                    if (out_if.shift_bits !== want.shift_bits) begin
                        $error("shift_bits expected %0d actual %0d",
                               want.shift_bits, out_if.shift_bits);
                        fail_cnt++;
                    end
                    if (out_if.bank_eight_bit !== want.bank_eight_bit) begin
                        $error("bank_eight_bit expected %0b actual %0b",
                               want.bank_eight_bit, out_if.bank_eight_bit);
                        fail_cnt++;
                    end
                    if (out_if.latch !== want.latch) begin
                        $error("latch expected %0b actual %0b", want.latch, out_if.latch);
                        fail_cnt++;
                    end
                    if (out_if.row_drive !== want.row_drive) begin
                        $error("row_drive expected %0h actual %0h",
                               want.row_drive, out_if.row_drive);
                        fail_cnt++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last expected %0b actual %0b", want.last, out_if.last);
                        fail_cnt++;
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_cmd(input logic [1:0] f, input logic [2:0] c, input logic [2:0] r,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
        t_scan_cmd cmd;
        cmd = '{func: f, col: c, row: r, red: red, green: green, blue: blue};
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endtask

    function automatic logic [7:0] pick_level();
        int k;
        k = $urandom_range(7);
        if (k == 0) begin
            return 8'h00;
        end else if (k == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic add_random_cmds(input int count);
        int         made;
        int         pick;
        logic [1:0] f;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 52) begin
                f = FUNC_WRITE;
            end else if (pick < 82) begin
                f = FUNC_REFRESH;
            end else if (pick < 94) begin
                f = FUNC_CAL;
            end else begin
                f = FUNC_UNUSED;
            end
            add_cmd(f, 3'($urandom_range(7)), 3'($urandom_range(7)),
                    pick_level(), pick_level(), pick_level());
            if (f != FUNC_UNUSED) begin
                made++;
            end
        end
    endtask

    task automatic drain();
        int guard;
        while (cmds_accepted != cmds_queued) begin
            @(posedge clk);
        end
        guard = 0;
        while (expected_beats.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cal(input logic [1:0] idx, input logic [5:0] val);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.data      <= val;
        do begin
            @(posedge clk);
        end while (!cfg_if.ready);
        cal_lvl[idx] = val;
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.func        = FUNC_WRITE;
        in_if.pixel_col   = '0;
        in_if.pixel_row   = '0;
        in_if.red_value   = '0;
        in_if.green_value = '0;
        in_if.blue_value  = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.reg_index  = REG_CAL_RED;
        cfg_if.data       = '0;
        cmds_queued       = 0;
        cmds_accepted     = 0;
        fail_cnt          = 0;
        cycle_cnt         = 0;
        hold_req          = 1'b0;
        snd_idle          = 16;
        rcv_idle          = 68;
        for (int i = 0; i < ROWS * COLS; i++) begin
            frame_px[i] = '0;
        end
        scan_row = '0;
        row_en   = '0;
        cal_lvl[REG_CAL_RED]   = CAL_RESET;
        cal_lvl[REG_CAL_GREEN] = CAL_RESET;
        cal_lvl[REG_CAL_BLUE]  = CAL_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Blank frame first, then corners and bit patterns, then a full wrap of the rows.
        add_cmd(FUNC_CAL,     3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        add_cmd(FUNC_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        add_cmd(FUNC_WRITE,   3'd0, 3'd1, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(FUNC_WRITE,   3'd7, 3'd1, 8'hAA, 8'h55, 8'h00);
        add_cmd(FUNC_WRITE,   3'd3, 3'd1, 8'h55, 8'hAA, 8'hFF);
        add_cmd(FUNC_UNUSED,  3'd0, 3'd1, 8'h12, 8'h34, 8'h56);
        add_cmd(FUNC_REFRESH, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(FUNC_WRITE,   3'd7, 3'd0, 8'h01, 8'h80, 8'h7F);
        add_cmd(FUNC_WRITE,   3'd0, 3'd7, 8'hFE, 8'h7F, 8'h80);
        add_cmd(FUNC_WRITE,   3'd7, 3'd7, 8'hFF, 8'h00, 8'hFF);
        add_cmd(FUNC_WRITE,   3'd7, 3'd7, 8'h00, 8'hFF, 8'h00);
        repeat (7) add_cmd(FUNC_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        add_cmd(FUNC_CAL,     3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        drain();

        write_cal(REG_CAL_RED,   6'd0);
        write_cal(REG_CAL_GREEN, 6'd0);
        write_cal(REG_CAL_BLUE,  6'd0);
        hold_req = 1'b1;
        repeat (4) add_cmd(FUNC_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        add_random_cmds(96);
        drain();

        write_cal(REG_CAL_BLUE,  6'd42);
        write_cal(REG_CAL_GREEN, 6'd21);
        write_cal(REG_CAL_RED,   6'd63);
        snd_idle = 68;
        rcv_idle = 16;
        add_random_cmds(100);
        drain();

        write_cal(REG_CAL_RED,   6'($urandom_range(63)));
        write_cal(REG_CAL_GREEN, 6'($urandom_range(63)));
        write_cal(REG_CAL_BLUE,  6'($urandom_range(63)));
        snd_idle = 0;
        rcv_idle = 0;
        add_random_cmds(94);
        add_cmd(FUNC_CAL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        drain();

        if (expected_beats.size() != 0) begin
            $error("%0d expected beats never arrived", expected_beats.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
